// ===== design/disc_neighbourhood_gradient_direction_defines.svh =====
// Assertion helpers for the checker file.
`ifndef DISC_NEIGHBOURHOOD_GRADIENT_DIRECTION_DEFINES_SVH
`define DISC_NEIGHBOURHOOD_GRADIENT_DIRECTION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DNGD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DNGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dngd_pkg.sv =====
`default_nettype none
package dngd_pkg;

  // Field and storage widths
  localparam int PixW       = 8;
  localparam int CoordW     = 8;
  localparam int OffW       = 6;
  localparam int AngW       = 16;
  localparam int IdxW       = 8;
  localparam int CntW       = 9;
  localparam int CfgW       = 9;
  localparam int DiffW      = 17;
  localparam int CmdW       = 2;
  localparam int FrameAddrW = 2 * CoordW;
  localparam int FrameDepth = 1 << FrameAddrW;
  localparam int TblDepth   = 1 << IdxW;
  localparam int TblW       = 2 * OffW + AngW;
  localparam int ScrW       = PixW + 1;
  localparam int SumW       = 16;
  localparam int AvgW       = 16;
  localparam int DivW       = SumW + 8;
  localparam int DivCntW    = 5;
  localparam int PaddrW     = 4;
  localparam int PdataW     = 32;

  // Register limits
  localparam logic [CfgW-1:0] MaxWidth      = 9'd256;
  localparam logic [CfgW-1:0] MaxHeight     = 9'd256;
  localparam logic [CfgW-1:0] MaxNeighbours = 9'd256;
  localparam logic [CfgW-1:0] MinNeighbours = 9'd2;

  // Command codes
  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_EVAL  = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_CENTRE, OP_CLASSIFY, OP_DIVIDE, OP_PAIRS,
    OP_WINIT, OP_SLIDE, OP_BEST, OP_ANGLE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
    logic idle;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic eval_req;
    logic done;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [CfgW-1:0] fw;
    logic [CfgW-1:0] fh;
    logic [CfgW-1:0] n;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/dngd_if.sv =====
`default_nettype none
interface dngd_in_if import dngd_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic [IdxW-1:0]        table_index;
  logic signed [OffW-1:0] row_offset;
  logic signed [OffW-1:0] col_offset;
  logic [AngW-1:0]        angle;
  logic [CoordW-1:0]      row;
  logic [CoordW-1:0]      col;
  logic [PixW-1:0]        pixel;

  modport source(output valid, command, table_index, row_offset, col_offset, angle,
                 row, col, pixel, input ready);
  modport sink(input valid, command, table_index, row_offset, col_offset, angle,
               row, col, pixel, output ready);
endinterface

interface dngd_out_if import dngd_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [CoordW-1:0]       out_row;
  logic [CoordW-1:0]       out_col;
  logic signed [DiffW-1:0] difference;
  logic [IdxW-1:0]         direction_index;
  logic [AngW-1:0]         direction_angle;

  modport source(output valid, out_row, out_col, difference, direction_index,
                 direction_angle, input ready);
  modport sink(input valid, out_row, out_col, difference, direction_index,
               direction_angle, output ready);
endinterface
`default_nettype wire

// ===== design/dngd_ram.sv =====
`default_nettype none
module dngd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

// ===== design/dngd_div.sv =====
`default_nettype none
module dngd_div import dngd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [CntW-1:0]    den_q;
  logic [CntW-1:0]    rem_q;
  logic [DivW-1:0]    quo_q;
  logic [CntW:0]      trial;
  logic               ge;
  logic [CntW:0]      diff;

  // One restoring step per cycle
  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CntW-1:0] : trial[CntW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== design/dngd_ctrl.sv =====
`default_nettype none
module dngd_ctrl import dngd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CENTRE, S_CLASSIFY, S_DIVIDE, S_PAIRS,
    S_WINIT, S_SLIDE, S_BEST, S_ANGLE, S_FINISH
  } state_e;

  state_e state_q;
  logic   start_q;

  // Sequencer: one pass per state, each pass entered with a start pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (stat_i.eval_req) begin
            state_q <= S_CENTRE;
            start_q <= 1'b1;
          end
        end
        S_CENTRE: begin
          if (stat_i.done) begin
            state_q <= S_CLASSIFY;
            start_q <= 1'b1;
          end
        end
        S_CLASSIFY: begin
          if (stat_i.done) begin
            state_q <= S_DIVIDE;
            start_q <= 1'b1;
          end
        end
        S_DIVIDE: begin
          if (stat_i.done) begin
            state_q <= S_PAIRS;
            start_q <= 1'b1;
          end
        end
        S_PAIRS: begin
          if (stat_i.done) begin
            state_q <= S_WINIT;
            start_q <= 1'b1;
          end
        end
        S_WINIT: begin
          if (stat_i.done) begin
            state_q <= S_SLIDE;
            start_q <= 1'b1;
          end
        end
        S_SLIDE: begin
          if (stat_i.done) begin
            state_q <= S_BEST;
            start_q <= 1'b1;
          end
        end
        S_BEST: begin
          if (stat_i.done) begin
            state_q <= S_ANGLE;
            start_q <= 1'b1;
          end
        end
        S_ANGLE: begin
          if (stat_i.done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!stat_i.out_full) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Pass selection seen by the datapath
  always_comb begin
    ctrl_o.start    = start_q;
    ctrl_o.idle     = (state_q == S_IDLE);
    ctrl_o.load_out = (state_q == S_FINISH) && !stat_i.out_full;
    unique case (state_q)
      S_CENTRE:   ctrl_o.op = OP_CENTRE;
      S_CLASSIFY: ctrl_o.op = OP_CLASSIFY;
      S_DIVIDE:   ctrl_o.op = OP_DIVIDE;
      S_PAIRS:    ctrl_o.op = OP_PAIRS;
      S_WINIT:    ctrl_o.op = OP_WINIT;
      S_SLIDE:    ctrl_o.op = OP_SLIDE;
      S_BEST:     ctrl_o.op = OP_BEST;
      S_ANGLE:    ctrl_o.op = OP_ANGLE;
      default:    ctrl_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/dngd_datapath.sv =====
`default_nettype none
module dngd_datapath import dngd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  dngd_in_if.sink    in_i,
  dngd_out_if.source out_o,
  input  cfg_t  cfg_i,
  input  ctrl_t ctrl_i,
  output stat_t stat_o
);

  logic accept;
  op_e  op;
  logic st;

  logic [CoordW-1:0] row_q, col_q;
  logic [PixW-1:0]   centre_q;

  // Pass bookkeeping
  logic [CntW-1:0] k_q;
  logic [CntW-1:0] limit;
  logic            issue;
  logic            s1_q, s2_q;
  logic [IdxW-1:0] idx1_q, idx2_q;
  logic            inb2_q;

  logic [IdxW-1:0] half;
  logic [IdxW-1:0] n_m1;

  // Memory ports
  logic [TblW-1:0]       tbl_rd;
  logic [IdxW-1:0]       tbl_ra;
  logic [PixW-1:0]       frm_rd;
  logic [FrameAddrW-1:0] frm_ra;
  logic                  scr_we;
  logic [IdxW-1:0]       scr_wa, scr_ra_a, scr_ra_b;
  logic [ScrW-1:0]       scr_wd, scr_a, scr_b;
  logic                  cnt_we;
  logic [IdxW-1:0]       cnt_wa;
  logic [CntW-1:0]       cnt_wd, cnt_rd;

  // Classification
  logic [OffW-1:0] tr, tc;
  logic [9:0]      r1, c1;
  logic            inb1;
  logic [PixW-1:0] v2;
  logic            bright2;
  logic [SumW-1:0] pos_q, neg_q;
  logic [CntW-1:0] posc_q, negc_q;

  // Division
  logic            div_go, div_go_b, div_done, dsel_q;
  logic [DivW-1:0] div_num, div_quo;
  logic [CntW-1:0] div_den;
  logic [AvgW-1:0] pavg_q, navg_q;

  // Window
  logic [IdxW-1:0] wstart_q, wend_q, wmid_q;
  logic [IdxW-1:0] wstart_nx, wend_nx, wmid_nx;
  logic [CntW-1:0] w_q, w_new;

  // Selection
  logic [IdxW-1:0] best_q;
  logic [CntW-1:0] bestw_q;
  logic [PixW-1:0] bestv_q;
  logic [AngW-1:0] angle_q;
  logic            take;
  logic            both;

  logic out_valid_q;

  assign op       = ctrl_i.op;
  assign st       = ctrl_i.start;
  assign in_i.ready = ctrl_i.idle;
  assign accept   = in_i.valid && in_i.ready;
  assign half     = cfg_i.n[CntW-1:1];
  assign n_m1     = IdxW'(cfg_i.n - 1'b1);

  // Capture the centre position of an evaluate
  always_ff @(posedge clk_i) begin
    if (accept && in_i.command == CMD_EVAL) begin
      row_q <= in_i.row;
      col_q <= in_i.col;
    end
  end

  // Memories
  assign tbl_ra = (op == OP_ANGLE) ? best_q : k_q[IdxW-1:0];
  dngd_ram #(.Width(TblW), .Depth(TblDepth)) u_tbl (
    .clk_i,
    .we_i      (accept && in_i.command == CMD_LOAD),
    .waddr_i   (in_i.table_index),
    .wdata_i   ({in_i.row_offset, in_i.col_offset, in_i.angle}),
    .raddr_a_i (tbl_ra),
    .rdata_a_o (tbl_rd),
    .raddr_b_i (tbl_ra),
    .rdata_b_o ()
  );

  assign frm_ra = (op == OP_CENTRE) ? {row_q, col_q} : {r1[CoordW-1:0], c1[CoordW-1:0]};
  dngd_ram #(.Width(PixW), .Depth(FrameDepth)) u_frm (
    .clk_i,
    .we_i      (accept && in_i.command == CMD_WRITE),
    .waddr_i   ({in_i.row, in_i.col}),
    .wdata_i   (in_i.pixel),
    .raddr_a_i (frm_ra),
    .rdata_a_o (frm_rd),
    .raddr_b_i (frm_ra),
    .rdata_b_o ()
  );

  dngd_ram #(.Width(ScrW), .Depth(TblDepth)) u_scr (
    .clk_i,
    .we_i      (scr_we),
    .waddr_i   (scr_wa),
    .wdata_i   (scr_wd),
    .raddr_a_i (scr_ra_a),
    .rdata_a_o (scr_a),
    .raddr_b_i (scr_ra_b),
    .rdata_b_o (scr_b)
  );

  dngd_ram #(.Width(CntW), .Depth(TblDepth)) u_cnt (
    .clk_i,
    .we_i      (cnt_we),
    .waddr_i   (cnt_wa),
    .wdata_i   (cnt_wd),
    .raddr_a_i (k_q[IdxW-1:0]),
    .rdata_a_o (cnt_rd),
    .raddr_b_i (k_q[IdxW-1:0]),
    .rdata_b_o ()
  );

  // Pass length and issue
  always_comb begin
    unique case (op)
      OP_CLASSIFY: limit = cfg_i.n;
      OP_PAIRS:    limit = {1'b0, half};
      OP_WINIT:    limit = {1'b0, half} + 1'b1;
      OP_SLIDE:    limit = cfg_i.n;
      OP_BEST:     limit = cfg_i.n;
      default:     limit = '0;
    endcase
  end
  assign issue = !st && (k_q < limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else if (st) begin
      k_q  <= (op == OP_SLIDE) ? CntW'(1) : '0;
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (issue) begin
        k_q <= k_q + 1'b1;
      end
      s1_q <= issue;
      s2_q <= s1_q && (op == OP_CLASSIFY);
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= (op == OP_SLIDE) ? wmid_nx : k_q[IdxW-1:0];
    idx2_q <= idx1_q;
    inb2_q <= inb1;
  end

  // Neighbour position and frame bounds
  assign tr   = tbl_rd[TblW-1 -: OffW];
  assign tc   = tbl_rd[AngW +: OffW];
  assign r1   = {2'b00, row_q} + {{4{tr[OffW-1]}}, tr};
  assign c1   = {2'b00, col_q} + {{4{tc[OffW-1]}}, tc};
  assign inb1 = !r1[9] && !c1[9] && (r1 < {1'b0, cfg_i.fh}) && (c1 < {1'b0, cfg_i.fw});

  assign v2      = inb2_q ? frm_rd : '0;
  assign bright2 = inb2_q && (v2 > centre_q);

  // Centre pixel and the two class sums
  always_ff @(posedge clk_i) begin
    if (op == OP_CENTRE && !st) begin
      centre_q <= frm_rd;
    end
    if (op == OP_CLASSIFY && st) begin
      pos_q  <= '0;
      neg_q  <= '0;
      posc_q <= '0;
      negc_q <= '0;
    end else if (s2_q && inb2_q) begin
      if (bright2) begin
        pos_q  <= pos_q + SumW'(v2);
        posc_q <= posc_q + 1'b1;
      end else begin
        neg_q  <= neg_q + SumW'(v2);
        negc_q <= negc_q + 1'b1;
      end
    end
  end

  // Opposite pair pruning
  assign both = scr_a[PixW] && scr_b[PixW];

  // Scratch write and read selection
  always_comb begin
    scr_we   = 1'b0;
    scr_wa   = idx2_q;
    scr_wd   = {bright2, v2};
    scr_ra_a = k_q[IdxW-1:0];
    scr_ra_b = k_q[IdxW-1:0] + half;
    if (op == OP_SLIDE) begin
      scr_ra_a = wstart_q;
      scr_ra_b = wend_nx;
    end
    if (s2_q) begin
      scr_we = 1'b1;
    end else if (op == OP_PAIRS && s1_q && both) begin
      scr_we = 1'b1;
      if (scr_a[PixW-1:0] > scr_b[PixW-1:0]) begin
        scr_wa = idx1_q + half;
        scr_wd = {1'b0, scr_b[PixW-1:0]};
      end else begin
        scr_wa = idx1_q;
        scr_wd = {1'b0, scr_a[PixW-1:0]};
      end
    end
  end

  // Two divisions on one shared divider
  assign div_go_b = (op == OP_DIVIDE) && div_done && !dsel_q;
  assign div_go   = ((op == OP_DIVIDE) && st) || div_go_b;
  assign div_num  = div_go_b ? {neg_q, 8'h00} : {pos_q, 8'h00};
  always_comb begin
    div_den = div_go_b ? negc_q : posc_q;
    if (div_den == '0) begin
      div_den = CntW'(1);
    end
  end

  dngd_div u_div (
    .clk_i,
    .rst_ni,
    .go_i       (div_go),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (op == OP_DIVIDE && st) begin
      dsel_q <= 1'b0;
    end else if (op == OP_DIVIDE && div_done) begin
      dsel_q <= 1'b1;
      if (!dsel_q) begin
        pavg_q <= (posc_q == '0) ? {centre_q, 8'h00} : div_quo[AvgW-1:0];
      end else begin
        navg_q <= (negc_q == '0) ? {centre_q, 8'h00} : div_quo[AvgW-1:0];
      end
    end
  end

  // Circular window counters
  assign wstart_nx = (wstart_q == n_m1) ? '0 : wstart_q + 1'b1;
  assign wend_nx   = (wend_q == n_m1) ? '0 : wend_q + 1'b1;
  assign wmid_nx   = (wmid_q == n_m1) ? '0 : wmid_q + 1'b1;
  assign w_new     = w_q - CntW'(scr_a[PixW]) + CntW'(scr_b[PixW]);

  always_ff @(posedge clk_i) begin
    if (op == OP_SLIDE && st) begin
      wstart_q <= '0;
      wend_q   <= half;
      wmid_q   <= half >> 1;
    end else if (op == OP_SLIDE && issue) begin
      wstart_q <= wstart_nx;
      wend_q   <= wend_nx;
      wmid_q   <= wmid_nx;
    end
    if (op == OP_WINIT && st) begin
      w_q <= '0;
    end else if (op == OP_WINIT && s1_q) begin
      w_q <= w_q + CntW'(scr_a[PixW]);
    end else if (op == OP_SLIDE && s1_q) begin
      w_q <= w_new;
    end
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = idx1_q;
    cnt_wd = w_new;
    if (op == OP_SLIDE && st) begin
      cnt_we = 1'b1;
      cnt_wa = half >> 1;
      cnt_wd = w_q;
    end else if (op == OP_SLIDE && s1_q) begin
      cnt_we = 1'b1;
    end
  end

  // Running best: larger count, then brighter neighbour, else earlier index
  assign take = (idx1_q == '0) || (cnt_rd > bestw_q) ||
                ((cnt_rd == bestw_q) && (scr_a[PixW-1:0] > bestv_q));

  always_ff @(posedge clk_i) begin
    if (op == OP_BEST && s1_q && take) begin
      best_q  <= idx1_q;
      bestw_q <= cnt_rd;
      bestv_q <= scr_a[PixW-1:0];
    end
    if (op == OP_ANGLE && !st) begin
      angle_q <= tbl_rd[AngW-1:0];
    end
  end

  // Pass completion
  always_comb begin
    unique case (op)
      OP_CENTRE, OP_ANGLE: stat_o.done = !st;
      OP_DIVIDE:           stat_o.done = div_done && dsel_q;
      OP_CLASSIFY, OP_PAIRS, OP_WINIT, OP_SLIDE, OP_BEST:
        stat_o.done = !st && !issue && !s1_q && !s2_q;
      default:             stat_o.done = 1'b0;
    endcase
  end

  assign stat_o.eval_req = in_i.valid && (in_i.command == CMD_EVAL);
  assign stat_o.out_full = out_valid_q && !out_o.ready;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_o.out_row         <= row_q;
      out_o.out_col         <= col_q;
      out_o.difference      <= DiffW'({1'b0, pavg_q} - {1'b0, navg_q});
      out_o.direction_index <= best_q;
      out_o.direction_angle <= angle_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
`default_nettype wire

// ===== design/disc_neighbourhood_gradient_direction.sv =====
// Disc-neighbourhood gradient and direction unit.
// Input channel in_i carries transactions of three kinds: a table load writes
// one neighbour entry, a pixel write stores one frame byte, an evaluate
// computes one result for a centre pixel. Loads and writes finish in the
// cycle they are accepted and give no result; they can follow each other
// every cycle. An evaluate holds the input off while it runs.
// An evaluate runs as a sequence of passes for n table entries: a centre
// read, one pass over the table to classify neighbours, two 24-step
// divisions on one shared divider, a pair pass, a window fill, a window
// slide, a best search and an angle lookup. The table passes are paced by
// the registered reads of the table, frame and scratch RAMs.
// Results sit in an output register: the next transaction is taken while a
// result waits, but a second result waits in its finish state until the
// receiver takes the first.
// Configuration goes through the APB port (width, height, count at 0, 4, 8);
// the user writes it only while idle, which the block does not enforce. Reset
// sets 256 x 256 and n = 2; the frame and table are undefined until written.
`default_nettype none
module disc_neighbourhood_gradient_direction import dngd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dngd_in_if.sink           in_i,
  dngd_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [CfgW-1:0] width_q, height_q, count_q;
  logic            cfg_wr;
  cfg_t            cfg;
  ctrl_t           ctrl;
  stat_t           stat;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MaxWidth;
      height_q <= MaxHeight;
      count_q  <= MinNeighbours;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[CfgW-1:0];
        REG_HEIGHT: height_q <= pwdata[CfgW-1:0];
        REG_COUNT:  count_q  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = PdataW'(width_q);
      REG_HEIGHT: prdata = PdataW'(height_q);
      REG_COUNT:  prdata = PdataW'(count_q);
      default:    prdata = '0;
    endcase
  end

  // Saturated working values
  always_comb begin
    cfg.fw = (width_q > MaxWidth) ? MaxWidth : width_q;
    cfg.fh = (height_q > MaxHeight) ? MaxHeight : height_q;
    priority if (count_q < MinNeighbours) begin
      cfg.n = MinNeighbours;
    end else if (count_q > MaxNeighbours) begin
      cfg.n = MaxNeighbours;
    end else begin
      cfg.n = count_q;
    end
  end

  dngd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  dngd_datapath u_dp (
    .clk_i,
    .rst_ni,
    .in_i,
    .out_o,
    .cfg_i  (cfg),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule
`default_nettype wire

// ===== design/dngd_checker.sv =====
`default_nettype none
`include "disc_neighbourhood_gradient_direction_defines.svh"
module dngd_checker import dngd_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic [CmdW-1:0] in_command_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [IdxW-1:0] out_index_i,
  input logic [AngW-1:0] out_angle_i
);

  // An accepted evaluate occupies the block
  `DNGD_ASSERT_NEXT(a_eval_busy, in_valid_i && in_ready_i && in_command_i == CMD_EVAL, !in_ready_i, "input still ready after evaluate")

  // Loads, writes and unused codes never stall the input
  `DNGD_ASSERT_NEXT(a_simple_free, in_valid_i && in_ready_i && in_command_i != CMD_EVAL, in_ready_i, "input stalled after a single-cycle transaction")

  // A stalled result stays offered
  `DNGD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // A stalled result keeps its payload
  `DNGD_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_index_i) && $stable(out_angle_i), "result changed while stalled")

endmodule

bind disc_neighbourhood_gradient_direction dngd_checker u_dngd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_index_i  (out_o.direction_index),
  .out_angle_i  (out_o.direction_angle)
);
`default_nettype wire

// ===== tb/disc_neighbourhood_gradient_direction_tb.sv =====
`timescale 1ns / 100ps
module disc_neighbourhood_gradient_direction_tb;
  import dngd_pkg::*;

  localparam int StallLimit = 20000;
  localparam int DrainWait  = 1200;
  localparam int HoldCycles = 3000;

  // Command code with no meaning to the block
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct {
    logic [CmdW-1:0]        command;
    logic [IdxW-1:0]        table_index;
    logic signed [OffW-1:0] row_offset;
    logic signed [OffW-1:0] col_offset;
    logic [AngW-1:0]        angle;
    logic [CoordW-1:0]      row;
    logic [CoordW-1:0]      col;
    logic [PixW-1:0]        pixel;
  } cmd_item_t;

  typedef struct {
    logic [CoordW-1:0] out_row;
    logic [CoordW-1:0] out_col;
    logic [DiffW-1:0]  difference;
    logic [IdxW-1:0]   direction_index;
    logic [AngW-1:0]   direction_angle;
  } grad_result_t;

  // Mirror of frame, neighbour table and registers; predicts one result per evaluate
  class gradient_scoreboard;
    logic [PixW-1:0] frame [FrameDepth];
    int              nb_row [TblDepth];
    int              nb_col [TblDepth];
    logic [AngW-1:0] nb_ang [TblDepth];
    int unsigned     frame_w, frame_h, nb_count;
    grad_result_t    expected_q[$];
    int              errors;

    function new();
      frame_w = 256;
      frame_h = 256;
      nb_count = 2;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned value);
      if (idx == REG_WIDTH) frame_w = value & 'h1FF;
      else if (idx == REG_HEIGHT) frame_h = value & 'h1FF;
      else if (idx == REG_COUNT) nb_count = value & 'h1FF;
    endfunction

    function void note_input(cmd_item_t it);
      int unsigned fw, fh, n, half, centre, pos, neg, posc, negc;
      int unsigned start, stop, mid, win, best, bestw;
      int          r, c, pavg, navg, diff;
      bit          bright [TblDepth];
      int unsigned values [TblDepth];
      int unsigned counts [TblDepth];
      grad_result_t res;
      if (it.command == CMD_LOAD) begin
        nb_row[it.table_index] = it.row_offset;
        nb_col[it.table_index] = it.col_offset;
        nb_ang[it.table_index] = it.angle;
        return;
      end
      if (it.command == CMD_WRITE) begin
        frame[{it.row, it.col}] = it.pixel;
        return;
      end
      if (it.command != CMD_EVAL) return;
      fw = (frame_w > 256) ? 256 : frame_w;
      fh = (frame_h > 256) ? 256 : frame_h;
      n = (nb_count < 2) ? 2 : ((nb_count > 256) ? 256 : nb_count);
      half = n / 2;
      centre = frame[{it.row, it.col}];
      pos = 0; neg = 0; posc = 0; negc = 0;
      // classify neighbours against the centre
      for (int k = 0; k < n; k++) begin
        r = int'(it.row) + nb_row[k];
        c = int'(it.col) + nb_col[k];
        if (r >= 0 && c >= 0 && r < int'(fh) && c < int'(fw)) begin
          values[k] = frame[r * 256 + c];
          bright[k] = values[k] > centre;
          if (bright[k]) begin
            pos += values[k]; posc++;
          end else begin
            neg += values[k]; negc++;
          end
        end else begin
          values[k] = 0;
          bright[k] = 0;
        end
      end
      pavg = posc ? int'((pos << 8) / posc) : int'(centre << 8);
      navg = negc ? int'((neg << 8) / negc) : int'(centre << 8);
      diff = pavg - navg;
      // opposite bright pairs keep the brighter one, later one on a tie
      for (int k = 0; k < half; k++) begin
        if (bright[k] && bright[k + half]) begin
          if (values[k] > values[k + half]) bright[k + half] = 0;
          else bright[k] = 0;
        end
      end
      // circular window of half+1 marks
      start = 0; stop = half; mid = half / 2; win = 0;
      for (int k = 0; k <= stop; k++) if (bright[k]) win++;
      counts[mid] = win;
      for (int k = 1; k < n; k++) begin
        if (bright[start]) win--;
        start = (start + 1) % n;
        stop = (stop + 1) % n;
        mid = (mid + 1) % n;
        if (bright[stop]) win++;
        counts[mid] = win;
      end
      best = 0; bestw = counts[0];
      for (int k = 1; k < n; k++) begin
        if (counts[k] > bestw || (counts[k] == bestw && values[k] > values[best])) begin
          best = k; bestw = counts[k];
        end
      end
      res.out_row = it.row;
      res.out_col = it.col;
      res.difference = diff[DiffW-1:0];
      res.direction_index = best[IdxW-1:0];
      res.direction_angle = nb_ang[best];
      expected_q.push_back(res);
    endfunction

    function void check_result(grad_result_t got);
      grad_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no evaluate outstanding: row %0d col %0d",
               got.out_row, got.out_col);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row); errors++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col); errors++;
      end
      if (got.difference !== want.difference) begin
        $error("difference: expected %0d, actual %0d",
               $signed(want.difference), $signed(got.difference)); errors++;
      end
      if (got.direction_index !== want.direction_index) begin
        $error("direction_index: expected %0d, actual %0d",
               want.direction_index, got.direction_index); errors++;
      end
      if (got.direction_angle !== want.direction_angle) begin
        $error("direction_angle: expected %0h, actual %0h",
               want.direction_angle, got.direction_angle); errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  dngd_in_if  in_bus ();
  dngd_out_if out_bus ();

  disc_neighbourhood_gradient_direction DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gradient_scoreboard sb = new();
  bit   pixel_written [FrameDepth];
  bit   calm;          // no idling on either side
  bit   hold_request;  // receiver holds off for a long stretch
  int   quiet_cycles = 0;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // Result check and stall watchdog
  always @(posedge clk) begin
    grad_result_t got;
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.out_row = out_bus.out_row;
        got.out_col = out_bus.out_col;
        got.difference = out_bus.difference;
        got.direction_index = out_bus.direction_index;
        got.direction_angle = out_bus.direction_angle;
        sb.check_result(got);
      end
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_item(cmd_item_t it);
    while (!calm && $urandom_range(99) < 17) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.command = it.command;
    in_bus.table_index = it.table_index;
    in_bus.row_offset = it.row_offset;
    in_bus.col_offset = it.col_offset;
    in_bus.angle = it.angle;
    in_bus.row = it.row;
    in_bus.col = it.col;
    in_bus.pixel = it.pixel;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(it);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  function automatic cmd_item_t blank_item(logic [CmdW-1:0] cmd);
    cmd_item_t it;
    it.command = cmd;
    it.table_index = IdxW'($urandom);
    it.row_offset = OffW'($urandom);
    it.col_offset = OffW'($urandom);
    it.angle = AngW'($urandom);
    it.row = CoordW'($urandom);
    it.col = CoordW'($urandom);
    it.pixel = PixW'($urandom);
    return it;
  endfunction

  task automatic load_entry(int idx, int roff, int coff, int ang);
    cmd_item_t it;
    it = blank_item(CMD_LOAD);
    it.table_index = IdxW'(idx);
    it.row_offset = OffW'(roff);
    it.col_offset = OffW'(coff);
    it.angle = AngW'(ang);
    push_item(it);
  endtask

  task automatic write_pixel(int r, int c, int value);
    cmd_item_t it;
    it = blank_item(CMD_WRITE);
    it.row = CoordW'(r);
    it.col = CoordW'(c);
    it.pixel = PixW'(value);
    pixel_written[r * 256 + c] = 1'b1;
    push_item(it);
  endtask

  // Writes the centre and any in-frame neighbour not yet stored, then evaluates
  task automatic evaluate_at(int r, int c);
    cmd_item_t it;
    int fw, fh, n, nr, nc;
    fw = (sb.frame_w > 256) ? 256 : sb.frame_w;
    fh = (sb.frame_h > 256) ? 256 : sb.frame_h;
    n = (sb.nb_count < 2) ? 2 : ((sb.nb_count > 256) ? 256 : sb.nb_count);
    if (!pixel_written[r * 256 + c]) write_pixel(r, c, $urandom_range(255));
    for (int k = 0; k < n; k++) begin
      nr = r + sb.nb_row[k];
      nc = c + sb.nb_col[k];
      if (nr >= 0 && nc >= 0 && nr < fh && nc < fw && !pixel_written[nr * 256 + nc])
        write_pixel(nr, nc, $urandom_range(255));
    end
    it = blank_item(CMD_EVAL);
    it.row = CoordW'(r);
    it.col = CoordW'(c);
    push_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  function automatic int pick_offset(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Random traffic for one register setting
  task automatic run_phase(int items, int span, int eval_pct);
    int fw, fh, pick;
    fw = (sb.frame_w > 256) ? 256 : sb.frame_w;
    fh = (sb.frame_h > 256) ? 256 : sb.frame_h;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < eval_pct) begin
        // centres mostly inside the frame, a few anywhere
        if (fw > 0 && fh > 0 && $urandom_range(9) != 0)
          evaluate_at($urandom_range(fh - 1), $urandom_range(fw - 1));
        else
          evaluate_at($urandom_range(255), $urandom_range(255));
      end else if (pick < eval_pct + 20) begin
        write_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else if (pick < 96) begin
        load_entry($urandom_range(255), pick_offset(span), pick_offset(span), $urandom);
      end else begin
        push_item(blank_item(CmdUnused));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    hold_request = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_LOAD;
    in_bus.table_index = '0;
    in_bus.row_offset = '0;
    in_bus.col_offset = '0;
    in_bus.angle = '0;
    in_bus.row = '0;
    in_bus.col = '0;
    in_bus.pixel = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // whole table loaded once, small offsets, ascending angles
    for (int k = 0; k < 256; k++) load_entry(k, pick_offset(3), pick_offset(3), k * 256);

    // directed: large offsets, centre extremes, empty classes, unused code
    load_entry(0, -31, -31, 16'h0000);
    load_entry(1, 31, 31, 16'hFFFF);
    write_pixel(0, 0, 0);
    write_pixel(255, 255, 255);
    evaluate_at(0, 0);
    evaluate_at(255, 255);
    write_pixel(128, 128, 255);
    evaluate_at(128, 128);
    write_pixel(64, 64, 0);
    evaluate_at(64, 64);
    push_item(blank_item(CmdUnused));
    load_entry(1, 1, -1, 16'h8000);
    load_entry(0, -1, 1, 16'h7FFF);
    evaluate_at(100, 100);
    evaluate_at(0, 255);
    evaluate_at(255, 0);

    // register settings, extremes among them; long hold-off in one phase
    wait_drained();
    write_reg(REG_WIDTH, 16);
    write_reg(REG_HEIGHT, 16);
    write_reg(REG_COUNT, 8);
    hold_request = 1'b1;
    run_phase(60, 3, 60);
    wait_drained();
    calm = 1'b1;
    write_reg(REG_COUNT, 17);
    write_reg(REG_WIDTH, 20);
    write_reg(REG_HEIGHT, 12);
    run_phase(50, 4, 55);
    wait_drained();
    calm = 1'b0;
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_COUNT, 0);
    run_phase(40, 2, 55);
    wait_drained();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 5);
    write_reg(REG_COUNT, 1);
    run_phase(30, 2, 55);
    wait_drained();
    write_reg(REG_WIDTH, 511);
    write_reg(REG_HEIGHT, 300);
    write_reg(REG_COUNT, 32);
    run_phase(20, 6, 50);
    wait_drained();
    write_reg(REG_WIDTH, 256);
    write_reg(REG_HEIGHT, 256);
    write_reg(REG_COUNT, 256);
    run_phase(4, 31, 50);
    wait_drained();
    write_reg(REG_COUNT, 511);
    write_reg(REG_WIDTH, 40);
    write_reg(REG_HEIGHT, 40);
    run_phase(6, 31, 50);
    wait_drained();
    write_reg(REG_WIDTH, 24);
    write_reg(REG_HEIGHT, 24);
    write_reg(REG_COUNT, 3);
    run_phase(60, 3, 60);
    wait_drained();
    write_reg(REG_COUNT, 12);
    run_phase(60, 5, 60);

    in_bus.valid = 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
